FILE: sv/j3d_pkg.sv
// ----------------------------------------------------------------------------
// j3d_pkg
// shared constants for the 3-D jacobi stencil solver
// ----------------------------------------------------------------------------
package j3d_pkg;
  localparam int unsigned GridMax = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_EDGE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAXIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_EPS = 2'd2;
  localparam logic CMD_RUN = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam logic [5:0] EDGE_RESET = 6'd32;
  localparam logic [15:0] MAXIT_RESET = 16'd1000;
  localparam logic [31:0] EPS_RESET = 32'h0080_0000;
  // floor(s/6) for s < 2^35: (s * ceil(2^38/6)) >> 38
  localparam logic [35:0] RECIP6 = 36'd45812984491;
  localparam int unsigned Recip6Shift = 38;
endpackage

FILE: sv/j3d_div6.sv
// ----------------------------------------------------------------------------
// j3d_div6
// truncating divide by six of a 35-bit sum: split multiply into registered partial products, combinational sum
// ----------------------------------------------------------------------------
module j3d_div6 import j3d_pkg::*; (
  input  logic        clk_i,
  input  logic [34:0] sum_i,
  output logic [31:0] quot_o
);
  logic [52:0] plo_q;
  logic [52:0] phi_q;
  logic [88:0] prod;

  always_ff @(posedge clk_i) begin
    plo_q <= 53'(sum_i * RECIP6[17:0]);
    phi_q <= 53'(sum_i * RECIP6[35:18]);
  end

  assign prod = {36'd0, plo_q} + {18'd0, phi_q, 18'd0};
  assign quot_o = prod[Recip6Shift+31:Recip6Shift];
endmodule

FILE: sv/jacobi_3d_stencil_solver.sv
// ----------------------------------------------------------------------------
// jacobi_3d_stencil_solver
// jacobi 7-point iteration over two on-chip grid memories
// run: fill both grids, then per iteration copy the interior of grid B into
//   grid A, run the stencil over the interior (neighbour read slots, divide,
//   write) and a convergence check; the done strobe follows the last check
// read: after the accepting edge the FSM passes S_RD_WAIT, then S_RD_OUT raises the done strobe
// one item in flight at a time; results cannot be stalled
// reset sets control and configuration registers; ra_q, rb_q and the grid memories hold no reset value
// ----------------------------------------------------------------------------
module jacobi_3d_stencil_solver import j3d_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic                cmd_i,
  input  logic [4:0]          pos_x_i,
  input  logic [4:0]          pos_y_i,
  input  logic [4:0]          pos_z_i,
  output logic                done,
  output logic                kind_o,
  output logic [15:0]         iterations_done_o,
  output logic [31:0]         final_change_o,
  output logic                converged_o,
  output logic [31:0]         voxel_value_o
);
  localparam int unsigned CW = $clog2(GridMax);
  localparam int unsigned AW = 3 * CW;
  localparam int unsigned Cells = GridMax * GridMax * GridMax;
  localparam int unsigned EW = $clog2(GridMax + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_COPY, S_COPY_END, S_ST_RD, S_ST_DIV, S_ST_WR,
    S_IT_END, S_RD_WAIT, S_RD_OUT
  } state_e;

  logic [31:0] mem_a [Cells];
  logic [31:0] mem_b [Cells];

  state_e      state_q;
  logic [5:0]  edge_cfg_q;
  logic [15:0] maxit_q;
  logic [31:0] thr_q;
  logic [EW-1:0] e_q, run_edge_q;
  logic [CW-1:0] x_q, y_q, z_q;
  logic [2:0]  nb_q;
  logic [34:0] sum_q;
  logic [31:0] eps_q;
  logic [15:0] it_q;
  logic        rd_ok_q;
  logic        copy_v_q;
  logic [AW-1:0] copy_a_q;
  logic [31:0] ra_q, rb_q;
  logic [31:0] quot;

  logic          a_re, a_we, b_we;
  logic [AW-1:0] a_raddr, a_waddr, b_waddr;
  logic [31:0]   a_wdata, b_wdata;

  logic [EW-1:0] e_clamp;
  logic [EW-1:0] ex, ey, ez;
  logic [EW-1:0] elast;
  logic          last_x, last_y, last_z, on_bound;
  logic [EW-1:0] nx, ny, nz;
  logic [31:0]   diff;
  logic [8:0]    init_sum;

  function automatic logic [AW-1:0] addr_of(input logic [EW-1:0] ax, input logic [EW-1:0] ay,
                                            input logic [EW-1:0] az);
    addr_of = {ax[CW-1:0], ay[CW-1:0], az[CW-1:0]};
  endfunction

  j3d_div6 u_div6 (.clk_i(clk_i), .sum_i(sum_q), .quot_o(quot));

  always_comb begin
    if (edge_cfg_q < 6'd3) e_clamp = EW'(3);
    else if (32'(edge_cfg_q) > GridMax) e_clamp = EW'(GridMax);
    else e_clamp = EW'(edge_cfg_q);
  end

  assign ex = EW'(x_q);
  assign ey = EW'(y_q);
  assign ez = EW'(z_q);
  assign elast = e_q - EW'(1);
  assign last_x = (ex == elast - EW'(1));
  assign last_y = (ey == elast - EW'(1));
  assign last_z = (ez == elast - EW'(1));
  assign on_bound = (ex == '0) || (ey == '0) || (ez == '0) || (ex == elast) || (ey == elast)
                    || (ez == elast);
  assign init_sum = 9'd4 + 9'(ex) + 9'(ey) + 9'(ez);
  assign diff = (rb_q > ra_q) ? rb_q - ra_q : ra_q - rb_q;

  always_comb begin
    nx = ex;
    ny = ey;
    nz = ez;
    unique case (nb_q)
      3'd0: nx = ex - EW'(1);
      3'd1: ny = ey - EW'(1);
      3'd2: nz = ez - EW'(1);
      3'd3: nz = ez + EW'(1);
      3'd4: ny = ey + EW'(1);
      3'd5: nx = ex + EW'(1);
      default: ;
    endcase
  end

  always_comb begin
    a_re = 1'b0;
    a_raddr = addr_of(ex, ey, ez);
    a_we = 1'b0;
    a_waddr = addr_of(ex, ey, ez);
    a_wdata = '0;
    b_we = 1'b0;
    b_waddr = addr_of(ex, ey, ez);
    b_wdata = '0;
    unique case (state_q)
      S_IDLE: begin
        a_re = start && cmd_i == CMD_READ;
        a_raddr = {pos_x_i[CW-1:0], pos_y_i[CW-1:0], pos_z_i[CW-1:0]};
      end
      S_FILL: begin
        a_we = 1'b1;
        b_we = 1'b1;
        b_wdata = on_bound ? '0
                : (init_sum > 9'd255 ? 32'hFFFF_FFFF : {init_sum[7:0], 24'd0});
      end
      S_COPY: begin
        a_re = 1'b1;
        a_we = copy_v_q;
        a_waddr = copy_a_q;
        a_wdata = rb_q;
      end
      S_COPY_END: begin
        a_we = copy_v_q;
        a_waddr = copy_a_q;
        a_wdata = rb_q;
      end
      S_ST_RD: begin
        a_re = nb_q < 3'd6;
        a_raddr = addr_of(nx, ny, nz);
      end
      S_ST_WR: begin
        b_we = 1'b1;
        b_wdata = quot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    if (a_re) ra_q <= mem_a[a_raddr];
    if (b_we) mem_b[b_waddr] <= b_wdata;
    rb_q <= mem_b[addr_of(ex, ey, ez)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      edge_cfg_q <= EDGE_RESET;
      maxit_q <= MAXIT_RESET;
      thr_q <= EPS_RESET;
      e_q <= EW'(3);
      run_edge_q <= '0;
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
      nb_q <= '0;
      sum_q <= '0;
      eps_q <= '0;
      it_q <= '0;
      rd_ok_q <= 1'b0;
      copy_v_q <= 1'b0;
      copy_a_q <= '0;
      busy <= 1'b0;
      done <= 1'b0;
      kind_o <= KIND_RUN;
      iterations_done_o <= '0;
      final_change_o <= '0;
      converged_o <= 1'b0;
      voxel_value_o <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_EDGE: edge_cfg_q <= cfg_data_i[5:0];
          CFG_MAXIT: maxit_q <= cfg_data_i[15:0];
          CFG_EPS: thr_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            if (cmd_i == CMD_READ) begin
              rd_ok_q <= (EW'(pos_x_i) < run_edge_q) && (EW'(pos_y_i) < run_edge_q)
                         && (EW'(pos_z_i) < run_edge_q);
              state_q <= S_RD_WAIT;
            end else begin
              e_q <= e_clamp;
              x_q <= '0;
              y_q <= '0;
              z_q <= '0;
              state_q <= S_FILL;
            end
          end
        end
        S_RD_WAIT: state_q <= S_RD_OUT;
        S_RD_OUT: begin
          done <= 1'b1;
          busy <= 1'b0;
          kind_o <= KIND_READ;
          iterations_done_o <= '0;
          final_change_o <= '0;
          converged_o <= 1'b0;
          voxel_value_o <= rd_ok_q ? ra_q : '0;
          state_q <= S_IDLE;
        end
        S_FILL: begin
          if (ez != elast) z_q <= z_q + CW'(1);
          else begin
            z_q <= '0;
            if (ey != elast) y_q <= y_q + CW'(1);
            else begin
              y_q <= '0;
              if (ex != elast) x_q <= x_q + CW'(1);
              else begin
                run_edge_q <= e_q;
                it_q <= '0;
                eps_q <= '0;
                if (maxit_q == '0) state_q <= S_IT_END;
                else begin
                  x_q <= CW'(1);
                  y_q <= CW'(1);
                  z_q <= CW'(1);
                  copy_v_q <= 1'b0;
                  state_q <= S_COPY;
                end
              end
            end
          end
        end
        S_COPY: begin
          // rb_q/ra_q now hold the previous voxel
          if (copy_v_q && diff > eps_q) eps_q <= diff;
          copy_v_q <= 1'b1;
          copy_a_q <= addr_of(ex, ey, ez);
          if (!last_z) z_q <= z_q + CW'(1);
          else begin
            z_q <= CW'(1);
            if (!last_y) y_q <= y_q + CW'(1);
            else begin
              y_q <= CW'(1);
              if (!last_x) x_q <= x_q + CW'(1);
              else begin
                x_q <= CW'(1);
                state_q <= S_COPY_END;
              end
            end
          end
        end
        S_COPY_END: begin
          if (diff > eps_q) eps_q <= diff;
          copy_v_q <= 1'b0;
          nb_q <= '0;
          sum_q <= '0;
          state_q <= S_ST_RD;
        end
        S_ST_RD: begin
          if (nb_q != 3'd0) sum_q <= sum_q + 35'(ra_q);
          if (nb_q == 3'd6) state_q <= S_ST_DIV;
          else nb_q <= nb_q + 3'd1;
        end
        S_ST_DIV: state_q <= S_ST_WR;
        S_ST_WR: begin
          nb_q <= '0;
          sum_q <= '0;
          state_q <= S_ST_RD;
          if (!last_z) z_q <= z_q + CW'(1);
          else begin
            z_q <= CW'(1);
            if (!last_y) y_q <= y_q + CW'(1);
            else begin
              y_q <= CW'(1);
              if (!last_x) x_q <= x_q + CW'(1);
              else begin
                x_q <= CW'(1);
                it_q <= it_q + 16'd1;
                state_q <= S_IT_END;
              end
            end
          end
        end
        S_IT_END: begin
          if (it_q != '0 && eps_q < thr_q || it_q == maxit_q) begin
            done <= 1'b1;
            busy <= 1'b0;
            kind_o <= KIND_RUN;
            iterations_done_o <= it_q;
            final_change_o <= eps_q;
            converged_o <= it_q != '0 && eps_q < thr_q;
            voxel_value_o <= '0;
            state_q <= S_IDLE;
          end else begin
            eps_q <= '0;
            copy_v_q <= 1'b0;
            state_q <= S_COPY;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !busy) else $error("done while busy");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item not busy");
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && kind_o == KIND_READ) |-> (iterations_done_o == '0 && !converged_o))
    else $error("read result carries run fields");
  a_run_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && kind_o == KIND_RUN) |-> (iterations_done_o <= maxit_q))
    else $error("iteration count beyond limit");
endmodule
